// File: rtl/crc32ws_pkg.sv
`default_nettype none

package crc32ws_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [1:0]  LAST_POS = 2'h3;

  // One byte request as seen by the accumulator
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } step_t;

  // Remainder of a nibble placed in the top four bits, shifted four times
  function automatic logic [31:0] crc_nibble(input logic [3:0] nib);
    logic [31:0] r;
    r = {nib, 28'h0};
    for (int k = 0; k < 4; k++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // 32 MSB-first shifts as eight nibble steps
  function automatic logic [31:0] crc_advance_word(input logic [31:0] crc,
                                                   input logic [31:0] word);
    logic [31:0] r;
    r = crc ^ word;
    for (int k = 0; k < 8; k++) begin
      r = {r[27:0], 4'h0} ^ crc_nibble(r[31:28]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crc32ws_accum.sv
`default_nettype none

module crc32ws_accum (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire crc32ws_pkg::step_t  step,
  output logic [31:0]              result
);
  import crc32ws_pkg::*;

  logic [31:0] crc_reg, crc_reg_next;
  logic [23:0] word_accum, word_accum_next;
  logic [1:0]  bytes_in_word, bytes_in_word_next;

  logic        word_full;
  logic [23:0] acc_mid;
  logic [1:0]  cnt_mid;
  logic [31:0] adv_word;
  logic        do_adv;

  always_comb begin
    word_full = step.present && (bytes_in_word == LAST_POS);
    if (step.present && !word_full) begin
      acc_mid = word_accum | (24'(step.data) << {bytes_in_word, 3'b000});
      cnt_mid = bytes_in_word + 2'd1;
    end else if (word_full) begin
      acc_mid = '0;
      cnt_mid = '0;
    end else begin
      acc_mid = word_accum;
      cnt_mid = bytes_in_word;
    end
    // A completed word and a padded final word never occur in the same request
    adv_word = word_full ? {step.data, word_accum} : {8'h00, acc_mid};
    do_adv   = word_full || (step.last && (cnt_mid != 2'd0));
    result   = do_adv ? crc_advance_word(crc_reg, adv_word) : crc_reg;

    if (step.last) begin
      crc_reg_next       = CRC_INIT;
      word_accum_next    = '0;
      bytes_in_word_next = '0;
    end else begin
      crc_reg_next       = result;
      word_accum_next    = acc_mid;
      bytes_in_word_next = cnt_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg       <= CRC_INIT;
      word_accum    <= '0;
      bytes_in_word <= '0;
    end else if (en) begin
      crc_reg       <= crc_reg_next;
      word_accum    <= word_accum_next;
      bytes_in_word <= bytes_in_word_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    en && step.last |=> crc_reg == CRC_INIT && bytes_in_word == 2'd0 && word_accum == 24'd0)
    else $error("accumulator not restarted after message end");

  a_count: assert property (@(posedge clk) disable iff (rst)
    en && !step.last && step.present && bytes_in_word != LAST_POS
    |=> bytes_in_word == $past(bytes_in_word) + 2'd1)
    else $error("byte count did not advance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(crc_reg) && $stable(bytes_in_word) && $stable(word_accum))
    else $error("state changed without a request");

endmodule

`default_nettype wire

// File: rtl/crc32_word_stream_zero_pad.sv
`default_nettype none

// channel | valid      | stall      | payload
// input   | byte_valid | byte_stall | data_byte, byte_present, last_byte
// output  | crc_valid  | crc_stall  | crc_value
//
// One request per cycle unless stalled; a CRC loads when its last request advances.
// Path: input register -> nibble-table CRC network -> output register.
// Reset (rst, sync) sets the CRC to all ones and empties both registers.
// A stalled output blocks only a request that carries the end of a message;
// byte requests keep flowing underneath a waiting CRC.

module crc32_word_stream_zero_pad (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last_byte,
  output logic             crc_valid,
  input  wire logic        crc_stall,
  output logic [31:0]      crc_value
);
  import crc32ws_pkg::*;

  logic        in_full;
  step_t       in_q;
  logic        advance;
  logic        accept;
  logic [31:0] result;

  assign advance    = in_full && (!in_q.last || !crc_valid || !crc_stall);
  assign byte_stall = in_full && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= '{data: data_byte, present: byte_present, last: last_byte};
    end
  end

  crc32ws_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .step   (in_q),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (advance && in_q.last) begin
      crc_valid <= 1'b1;
    end else if (!crc_stall) begin
      crc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q.last) begin
      crc_value <= result;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> crc_valid && crc_stall && in_q.last)
    else $error("input stalled without a blocked result");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.last |=> crc_valid && crc_value == $past(result))
    else $error("result not loaded");

  a_result_drain: assert property (@(posedge clk) disable iff (rst)
    crc_valid && !crc_stall && !(advance && in_q.last) |=> !crc_valid)
    else $error("result delivered twice");

endmodule

`default_nettype wire

// File: dv/crc32_word_stream_zero_pad_tb.sv
`timescale 1ns / 100ps

module crc32_word_stream_zero_pad_tb;
  import crc32ws_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_REQS = 1950;
  localparam int DRAIN_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        last_byte = 1'b0;
  logic        crc_valid;
  logic        crc_stall = 1'b0;
  logic [31:0] crc_value;

  crc32_word_stream_zero_pad dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .crc_valid    (crc_valid),
    .crc_stall    (crc_stall),
    .crc_value    (crc_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the message in flight
  logic [31:0] msg_crc = CRC_INIT;
  logic [23:0] part_word = '0;
  logic [1:0]  part_cnt = '0;

  logic [31:0] pending_crcs [$];
  int          mismatches = 0;
  bit          hold_req = 1'b0;

  // Directed rows; crc is typed in only where fixed is set
  typedef struct packed {
    step_t       req;
    logic        fixed;
    logic [31:0] crc;
  } dir_row_t;

  dir_row_t dir_rows [24] = '{
    {8'h00, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},  // empty message right after reset
    {8'hFF, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000},  // word cancels the init, ends on boundary
    {8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    {8'hA5, 1'b0, 1'b0, 1'b0, 32'h0},          // data without present flag
    {8'h3C, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'hFF, 1'b0, 1'b1, 1'b0, 32'h0},          // bare end closes a partial word
    {8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h80, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h7F, 1'b1, 1'b1, 1'b0, 32'h0},
    {8'h12, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h34, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h56, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h78, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h9A, 1'b1, 1'b1, 1'b0, 32'h0},
    {8'hC3, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF},
    {8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    {8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    {8'hFF, 1'b0, 1'b0, 1'b0, 32'h0},
    {8'h5A, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF}
  };

  // Bit-serial MSB-first division, one shift per bit
  function automatic logic [31:0] crc_shift_word(input logic [31:0] crc,
                                                 input logic [31:0] word);
    logic [31:0] r;
    r = crc ^ word;
    for (int k = 0; k < 32; k++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Returns 1 when the request closes a message; crc_out is then valid
  function automatic bit absorb_request(input step_t s, output logic [31:0] crc_out);
    if (s.present) begin
      if (part_cnt == LAST_POS) begin
        msg_crc = crc_shift_word(msg_crc, {s.data, part_word});
        part_word = '0;
        part_cnt = '0;
      end else begin
        part_word[part_cnt*8 +: 8] = s.data;
        part_cnt = part_cnt + 2'd1;
      end
    end
    crc_out = msg_crc;
    if (!s.last) return 1'b0;
    if (part_cnt != 2'd0) crc_out = crc_shift_word(msg_crc, {8'h00, part_word});
    msg_crc = CRC_INIT;
    part_word = '0;
    part_cnt = '0;
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH @%0t: %s got %08h want %08h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(input step_t s, input bit fixed, input logic [31:0] fixed_crc,
                              input bit idle_ok);
    int          gap;
    logic [31:0] crc_out;
    gap = idle_ok ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      byte_valid   <= 1'b0;
      data_byte    <= 8'($urandom);
      byte_present <= 1'($urandom_range(0, 1));
      last_byte    <= 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    byte_valid   <= 1'b1;
    data_byte    <= s.data;
    byte_present <= s.present;
    last_byte    <= s.last;
    do @(posedge clk); while (byte_stall);
    if (absorb_request(s, crc_out)) pending_crcs.push_back(fixed ? fixed_crc : crc_out);
  endtask

  always @(posedge clk) begin
    if (!rst && crc_valid && !crc_stall) begin
      if (pending_crcs.size() == 0) begin
        report_mismatch("crc with no request behind it", crc_value, 32'h0);
      end else begin
        if (crc_value !== pending_crcs[0])
          report_mismatch("crc_value", crc_value, pending_crcs[0]);
        void'(pending_crcs.pop_front());
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          crc_stall <= 1'b1;
        end
      end
      n = idle_len();
      repeat (n) begin
        @(negedge clk);
        crc_stall <= 1'b1;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      repeat (n) begin
        @(negedge clk);
        crc_stall <= 1'b0;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    step_t s;
    int    counted;
    int    len;
    int    tight;
    int    drain;
    bit    idle_ok;
    bit    end_on_byte;
    bit    pressed;

    counted = 0;
    tight = 0;
    pressed = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].crc, 1'b1);

    while (counted < RANDOM_REQS) begin
      // halfway: receiver backs off while we pour in short messages back to back
      if (!pressed && counted > RANDOM_REQS / 2) begin
        hold_req = 1'b1;
        pressed = 1'b1;
        tight = 40;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      idle_ok = ($urandom_range(0, 3) != 0);
      if (tight > 0) begin
        len = $urandom_range(0, 2);
        idle_ok = 1'b0;
        tight--;
      end
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          s.data = 8'($urandom);
          s.present = 1'b0;
          s.last = 1'b0;
          send_request(s, 1'b0, '0, idle_ok);
          counted++;
        end
        s.data = 8'($urandom);
        s.present = 1'b1;
        s.last = end_on_byte && (i == len - 1);
        send_request(s, 1'b0, '0, idle_ok);
      end
      if (!end_on_byte) begin
        s.data = 8'($urandom);
        s.present = 1'b0;
        s.last = 1'b1;
        send_request(s, 1'b0, '0, idle_ok);
      end
      counted += len + (end_on_byte ? 0 : 1);
    end

    @(negedge clk);
    byte_valid <= 1'b0;

    drain = 0;
    while (pending_crcs.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_crcs.size() != 0)
      report_mismatch("crc never arrived", 32'h0, pending_crcs[0]);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
